### hw/rtl/wfha_pkg.sv
// ----------------------------------------------------------------------------
// wfha_pkg
// Shared types and constants for the worst-fit hole allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package wfha_pkg;

   localparam int NUM_HOLES_DEF = 16;
   localparam int SIZE_BITS_DEF = 16;

   localparam int SLOT_W   = 4;
   localparam int AMOUNT_W = 16;

   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_REQUEST = 1'b1;

   typedef struct packed {
      logic                func;
      logic [SLOT_W-1:0]   hole_slot;
      logic [AMOUNT_W-1:0] amount;
   } req_type;

   typedef struct packed {
      logic                granted;
      logic [SLOT_W-1:0]   chosen_hole;
      logic [AMOUNT_W-1:0] space_left;
      logic [AMOUNT_W-1:0] space_used;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_LAST,
      ST_UPDATE
   } state_type;

   // write control for the hole table
   typedef struct packed {
      logic wr_en;
      logic wr_full;
   } tbl_ctl_type;

endpackage : wfha_pkg

`default_nettype wire

### hw/rtl/wfha_table.sv
// ----------------------------------------------------------------------------
// wfha_table
// Hole table: remaining and occupied space in memory, full and valid marks
// in flops. One write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wfha_table
   import wfha_pkg::*;
#(
   parameter int NUM_HOLES = NUM_HOLES_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF,
   localparam int IDX_W = $clog2(NUM_HOLES)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tbl_ctl_type          ctl,
   input  wire logic [IDX_W-1:0]     wr_addr,
   input  wire logic [SIZE_BITS-1:0] wr_rem,
   input  wire logic [SIZE_BITS-1:0] wr_occ,
   input  wire logic [IDX_W-1:0]     rd_addr,
   output logic      [SIZE_BITS-1:0] rd_rem,
   output logic      [SIZE_BITS-1:0] rd_occ,
   output logic                      rd_full
);

   logic [SIZE_BITS-1:0] rem_mem [NUM_HOLES];
   logic [SIZE_BITS-1:0] occ_mem [NUM_HOLES];

   logic [NUM_HOLES-1:0] valid_ff;
   logic [NUM_HOLES-1:0] full_ff;

   logic [SIZE_BITS-1:0] rem_q_ff;
   logic [SIZE_BITS-1:0] occ_q_ff;
   logic                 valid_q_ff;
   logic                 full_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         rem_mem[wr_addr] <= wr_rem;
         occ_mem[wr_addr] <= wr_occ;
      end
      rem_q_ff <= rem_mem[rd_addr];
      occ_q_ff <= occ_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         full_ff    <= '0;
         valid_q_ff <= 1'b0;
         full_q_ff  <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
            full_ff[wr_addr]  <= ctl.wr_full;
         end
         valid_q_ff <= valid_ff[rd_addr];
         full_q_ff  <= full_ff[rd_addr];
      end
   end

   // never-written entries read as an empty, non-full hole
   assign rd_rem  = valid_q_ff ? rem_q_ff : '0;
   assign rd_occ  = valid_q_ff ? occ_q_ff : '0;
   assign rd_full = valid_q_ff & full_q_ff;

endmodule : wfha_table

`default_nettype wire

### hw/rtl/wfha_alu.sv
// ----------------------------------------------------------------------------
// wfha_alu
// Shared subtract/compare unit: difference, a >= b and a == b.
// ----------------------------------------------------------------------------
`default_nettype none

module wfha_alu
   import wfha_pkg::*;
#(
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  wire logic [SIZE_BITS-1:0] op_a,
   input  wire logic [SIZE_BITS-1:0] op_b,
   output logic      [SIZE_BITS-1:0] diff,
   output logic                      ge,
   output logic                      eq
);

   logic [SIZE_BITS:0] wide_diff;

   assign wide_diff = {1'b0, op_a} - {1'b0, op_b};
   assign diff      = wide_diff[SIZE_BITS-1:0];
   assign ge        = ~wide_diff[SIZE_BITS];
   assign eq        = (wide_diff[SIZE_BITS-1:0] == '0) & ~wide_diff[SIZE_BITS];

endmodule : wfha_alu

`default_nettype wire

### hw/rtl/worst_fit_hole_allocator_core.sv
// ----------------------------------------------------------------------------
// worst_fit_hole_allocator_core: a load writes entry and result in ST_LOAD
// once the output is free. Request: one table read per hole through one
// comparator. Next input taken only back in ST_IDLE after the result.
// Reset is synchronous; the hole table reads as all zero, nothing full.
// ----------------------------------------------------------------------------
`default_nettype none

module worst_fit_hole_allocator_core
   import wfha_pkg::*;
#(
   parameter int NUM_HOLES = NUM_HOLES_DEF,
   parameter int SIZE_BITS = SIZE_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   localparam int IDX_W = $clog2(NUM_HOLES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_HOLES - 1);

   state_type            state_ff, state_in;
   req_type              item_ff, item_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 pend_ff, pend_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     best_idx_ff, best_idx_in;
   logic [SIZE_BITS-1:0] best_rem_ff, best_rem_in;
   logic [SIZE_BITS-1:0] best_occ_ff, best_occ_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   tbl_ctl_type          tbl_ctl;
   logic [IDX_W-1:0]     wr_addr;
   logic [SIZE_BITS-1:0] wr_rem, wr_occ;
   logic [SIZE_BITS-1:0] rd_rem, rd_occ;
   logic                 rd_full;

   logic [SIZE_BITS-1:0] alu_a, alu_b, alu_diff;
   logic                 alu_ge, alu_eq;

   logic [SIZE_BITS-1:0] amt;
   logic                 out_free;
   logic                 slot_ok;
   logic                 req_xfer;

   assign amt      = SIZE_BITS'(item_ff.amount);
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign slot_ok  = 32'(item_ff.hole_slot) < NUM_HOLES;
   assign req_xfer = req_valid & ~req_stall;

   wfha_table #(
      .NUM_HOLES (NUM_HOLES),
      .SIZE_BITS (SIZE_BITS)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (tbl_ctl),
      .wr_addr (wr_addr),
      .wr_rem  (wr_rem),
      .wr_occ  (wr_occ),
      .rd_addr (idx_ff),
      .rd_rem  (rd_rem),
      .rd_occ  (rd_occ),
      .rd_full (rd_full)
   );

   wfha_alu #(
      .SIZE_BITS (SIZE_BITS)
   ) u_alu (
      .op_a (alu_a),
      .op_b (alu_b),
      .diff (alu_diff),
      .ge   (alu_ge),
      .eq   (alu_eq)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      idx_ff      <= idx_in;
      rd_idx_ff   <= idx_ff;
      best_idx_ff <= best_idx_in;
      best_rem_ff <= best_rem_in;
      best_occ_ff <= best_occ_in;
      rsp_ff      <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      idx_in       = idx_ff;
      pend_in      = 1'b0;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_rem_in  = best_rem_ff;
      best_occ_in  = best_occ_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      req_stall    = 1'b1;
      tbl_ctl      = '0;
      wr_addr      = best_idx_ff;
      wr_rem       = alu_diff;
      wr_occ       = best_occ_ff + amt;

      // scan compare: first fit uses >= request, later ones need > best so far
      alu_a = rd_rem;
      alu_b = found_ff ? best_rem_ff : amt;
      if (state_ff == ST_UPDATE) begin
         alu_a = best_rem_ff;
         alu_b = amt;
      end

      if ((state_ff == ST_SCAN || state_ff == ST_LAST) && pend_ff) begin
         if (!rd_full && alu_ge && !(found_ff && alu_eq)) begin
            found_in    = 1'b1;
            best_idx_in = rd_idx_ff;
            best_rem_in = rd_rem;
            best_occ_in = rd_occ;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               item_in  = req_payload;
               idx_in   = '0;
               found_in = 1'b0;
               state_in = (req_payload.func == FUNC_LOAD) ? ST_LOAD : ST_SCAN;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               tbl_ctl.wr_en   = slot_ok;
               tbl_ctl.wr_full = 1'b0;
               wr_addr         = IDX_W'(item_ff.hole_slot);
               wr_rem          = amt;
               wr_occ          = '0;
               rsp_valid_in    = 1'b1;
               rsp_in          = '0;
               if (slot_ok) begin
                  rsp_in.granted     = 1'b1;
                  rsp_in.chosen_hole = item_ff.hole_slot;
                  rsp_in.space_left  = AMOUNT_W'(amt);
               end
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            pend_in = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (out_free) begin
               tbl_ctl.wr_en   = found_ff;
               tbl_ctl.wr_full = alu_eq;
               rsp_valid_in    = 1'b1;
               rsp_in          = '0;
               if (found_ff) begin
                  rsp_in.granted     = 1'b1;
                  rsp_in.chosen_hole = SLOT_W'(best_idx_ff);
                  rsp_in.space_left  = AMOUNT_W'(alu_diff);
                  rsp_in.space_used  = AMOUNT_W'(wr_occ);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // a refused item reports nothing but zeros
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.granted |->
         rsp_payload.chosen_hole == '0 && rsp_payload.space_left == '0 &&
         rsp_payload.space_used == '0)
      else $error("refused result carries nonzero fields");

   // once the scan ends, the running best fits the request
   assert property (@(posedge clock) disable iff (reset)
      found_ff && (state_ff == ST_LAST || state_ff == ST_UPDATE) |->
         best_rem_ff >= amt)
      else $error("best hole smaller than request");

   // an accepted request starts the scan at hole zero
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_payload.func == FUNC_REQUEST |=>
         state_ff == ST_SCAN && idx_ff == '0 && !found_ff)
      else $error("scan did not start cleanly");

   // the input side is closed while a request is in flight
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN || state_ff == ST_LAST || state_ff == ST_UPDATE |->
         req_stall)
      else $error("input open during scan");

endmodule : worst_fit_hole_allocator_core

`default_nettype wire
